[sv/msk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package msk_pkg;

  localparam int unsigned NUM_STACKS_DEF  = 4;
  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [SEL_W-1:0]         stack_select;
    logic signed [WORD_W-1:0] push_value;
  } msk_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
  } msk_rsp_t;

endpackage

`default_nettype wire

[sv/multi_stack_engine_unit.sv]
// multi_stack_engine_unit: a set of independent lifo stacks in one word memory
//
// request channel (in_*): one request per accepted valid/stall handshake,
// carrying a command (push, pop or peek), a stack index and a push value
// response channel (out_*): exactly one response per request, in order,
// carrying the popped or peeked word and a status (ok, overflow, underflow)
// errors, unused command codes and out-of-range stack indexes leave the
// stacks unchanged and return a zero word
//
// a request passes the in-flight register and then the response register
// before it shows on out_valid_o; throughput is one request per cycle
// while the receiver does not stall, set by the single memory port, which
// serves one read or one write per request
// fill counts sit in flip-flops and are updated at acceptance, so a request
// directly behind another already sees its effect on the memory address
//
// reset clears all fill counts (all stacks empty) and empties the pipeline;
// the memory itself is not cleared, since only pushed entries are read
// when the receiver stalls, the response register holds, the one request in
// flight waits with its read data held, and in_stall_o rises to block input
`timescale 1ns / 1ps
`default_nettype none

module multi_stack_engine_unit
  import msk_pkg::*;
#(
  parameter int unsigned NUM_STACKS  = NUM_STACKS_DEF,
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire msk_req_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output msk_rsp_t      out_rsp_o
);

  // derived sizes
  localparam int unsigned MemDepth = NUM_STACKS * STACK_DEPTH;
  localparam int unsigned AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int unsigned FillW    = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  // fill count per stack
  logic [FillW-1:0] fill_q [NUM_STACKS];
  logic [FillW-1:0] fill_d;
  logic             fill_we;

  // word memory, one port, registered read
  logic [WORD_W-1:0] mem_q [MemDepth];
  logic [WORD_W-1:0] mem_rdata_q;
  logic [AddrW-1:0]  mem_addr;
  logic              mem_we;
  logic              mem_re;

  // request in flight: memory read data arrives here
  logic          s1_valid_q;
  logic          s1_use_mem_q;
  logic          s1_use_mem_d;
  status_e       s1_status_q;
  status_e       s1_status_d;

  // response register
  logic          out_valid_q;
  msk_rsp_t      out_rsp_q;

  logic          in_accept;
  logic          out_load;
  logic          s1_free;
  logic          in_range;
  logic [IdxW-1:0]  sel_idx;
  logic [FillW-1:0] fill_cur;
  logic [AddrW-1:0] base_addr;
  logic [AddrW-1:0] push_addr;
  logic [AddrW-1:0] top_addr;

  // response register takes the in-flight request when empty or draining
  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || out_load;
  assign in_stall_o = !s1_free;
  assign in_accept  = in_valid_i && s1_free;

  assign in_range  = (32'(in_req_i.stack_select) < NUM_STACKS);
  assign sel_idx   = IdxW'(in_req_i.stack_select);
  assign fill_cur  = in_range ? fill_q[sel_idx] : '0;
  assign base_addr = AddrW'(AddrW'(sel_idx) * AddrW'(STACK_DEPTH));
  assign push_addr = base_addr + AddrW'(fill_cur);
  assign top_addr  = base_addr + AddrW'(fill_cur) - AddrW'(1);

  // decode: pick memory access, fill update and status
  always_comb begin
    fill_d       = fill_cur;
    fill_we      = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = top_addr;
    s1_use_mem_d = 1'b0;
    s1_status_d  = ST_OK;
    if (in_accept && in_range) begin
      unique case (in_req_i.command)
        CMD_PUSH: begin
          if (fill_cur == FillW'(STACK_DEPTH)) begin
            s1_status_d = ST_OVERFLOW;
          end else begin
            mem_we   = 1'b1;
            mem_addr = push_addr;
            fill_d   = fill_cur + FillW'(1);
            fill_we  = 1'b1;
          end
        end
        CMD_POP, CMD_PEEK: begin
          if (fill_cur == '0) begin
            s1_status_d = ST_UNDERFLOW;
          end else begin
            mem_re       = 1'b1;
            s1_use_mem_d = 1'b1;
            if (in_req_i.command == CMD_POP) begin
              fill_d  = fill_cur - FillW'(1);
              fill_we = 1'b1;
            end
          end
        end
        default: begin
          // unused command code: no effect
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (fill_we) begin
      fill_q[sel_idx] <= fill_d;
    end
  end

  // memory write and registered read; read data holds while no new read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= in_req_i.push_value;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_use_mem_q <= s1_use_mem_d;
      s1_status_q  <= s1_status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_rsp_q.read_value <= s1_use_mem_q ? mem_rdata_q : '0;
      out_rsp_q.status     <= s1_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

[sv/msk_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module msk_checker
  import msk_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire msk_rsp_t out_rsp_o
);

  // a stalled response stays offered
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped under stall");

  // a stalled response keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_rsp_o))
    else $error("response changed under stall");

  // a status code is never the unused one
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.status == ST_OK || out_rsp_o.status == ST_OVERFLOW ||
                     out_rsp_o.status == ST_UNDERFLOW))
    else $error("bad status code");

  // errors return a zero word
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_OK |-> out_rsp_o.read_value == '0)
    else $error("nonzero word on error");

  // a fresh response rises only behind an accepted request
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("response without request");

endmodule

bind multi_stack_engine_unit msk_checker u_msk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import msk_pkg::*;

  localparam int unsigned NSTK  = NUM_STACKS_DEF;
  localparam int unsigned DEPTH = STACK_DEPTH_DEF;

  // command code with no operation behind it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 800;
  // drain wait after the last response
  localparam int DRAIN_CYCLES = 8;
  // overall time limit for a run of roughly 850 requests
  localparam int LIMIT_NS = 400000;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_TOGGLE, STALL_RUNS} stall_mode_e;
  typedef enum int {BIAS_PUSH, BIAS_POP, BIAS_MIX} op_bias_e;

  // one row of the directed table; typed rows carry their own response
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [SEL_W-1:0]  sel;
    logic [WORD_W-1:0] val;
    int                reps;
    bit                typed;
    msk_rsp_t          rsp;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  msk_req_t in_req;
  logic     out_valid;
  logic     out_stall;
  msk_rsp_t out_rsp;

  // shadow copy of the stacks
  int unsigned       fill_cnt   [NSTK];
  logic [WORD_W-1:0] stack_words[NSTK][DEPTH];

  msk_rsp_t pending_rsp_q[$];
  dir_row_t dir_table[$];
  int       error_count = 0;

  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          stall_run  = 0;

  multi_stack_engine_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d responses outstanding", pending_rsp_q.size());
    $display("Verification failed");
    $finish;
  end

  // stack behavior: push unless full, pop/peek unless empty, errors leave state alone
  function automatic msk_rsp_t apply_stack_op(input msk_req_t r);
    msk_rsp_t    rsp;
    int unsigned sel;
    int unsigned fill;
    rsp.read_value = '0;
    rsp.status     = ST_OK;
    sel = r.stack_select;
    if (sel < NSTK) begin
      fill = fill_cnt[sel];
      if (r.command == CMD_PUSH) begin
        if (fill >= DEPTH) begin
          rsp.status = ST_OVERFLOW;
        end else begin
          stack_words[sel][fill] = r.push_value;
          fill_cnt[sel] = fill + 1;
        end
      end else if (r.command == CMD_POP || r.command == CMD_PEEK) begin
        if (fill == 0) begin
          rsp.status = ST_UNDERFLOW;
        end else begin
          rsp.read_value = stack_words[sel][fill-1];
          if (r.command == CMD_POP) fill_cnt[sel] = fill - 1;
        end
      end
    end
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("mismatch %s: got %h want %h at %0t ns", what, got, want, $time);
    error_count++;
  endtask

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel,
                         input logic [WORD_W-1:0] val, input int reps, input bit typed,
                         input logic [WORD_W-1:0] rd, input logic [STAT_W-1:0] st);
    dir_row_t row;
    row.cmd  = cmd;
    row.sel  = sel;
    row.val  = val;
    row.reps = reps;
    row.typed = typed;
    row.rsp.read_value = rd;
    row.rsp.status     = st;
    dir_table.push_back(row);
  endtask

  // hold a request until accepted, then record what it must return
  task automatic send_req(input msk_req_t r, input bit typed, input msk_rsp_t typed_rsp);
    msk_rsp_t predicted;
    @(negedge clk);
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = apply_stack_op(r);
    pending_rsp_q.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // sender pause until the block has answered everything
  task automatic wait_drained();
    idle_cycles(1);
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  function automatic msk_req_t random_req(input op_bias_e bias, input logic [SEL_W-1:0] focus);
    msk_req_t r;
    int       roll;
    roll = $urandom_range(0, 99);
    case (bias)
      BIAS_PUSH: r.command = roll < 65 ? CMD_PUSH : roll < 80 ? CMD_POP :
                             roll < 94 ? CMD_PEEK : CMD_UNUSED;
      BIAS_POP:  r.command = roll < 20 ? CMD_PUSH : roll < 70 ? CMD_POP :
                             roll < 94 ? CMD_PEEK : CMD_UNUSED;
      default:   r.command = roll < 40 ? CMD_PUSH : roll < 70 ? CMD_POP :
                             roll < 92 ? CMD_PEEK : CMD_UNUSED;
    endcase
    // mostly hammer one stack so it reaches full and empty
    r.stack_select = ($urandom_range(0, 99) < 70) ? focus : SEL_W'($urandom_range(0, NSTK-1));
    case ($urandom_range(0, 9))
      0:       r.push_value = 32'sh7FFF_FFFF;
      1:       r.push_value = 32'sh8000_0000;
      2:       r.push_value = '1;
      3:       r.push_value = '0;
      default: r.push_value = $urandom;
    endcase
    return r;
  endfunction

  // receiver stall pattern, switches style each time mode_left runs out
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_TOGGLE: out_stall <= ~out_stall;
      default: begin
        if (stall_run == 0) begin
          out_stall <= ~out_stall;
          stall_run <= $urandom_range(1, 8);
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  // response check against the oldest expectation
  always @(posedge clk) begin
    msk_rsp_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("unexpected response", out_rsp.read_value, '0);
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_rsp.read_value !== want.read_value)
          report_mismatch("read_value", out_rsp.read_value, want.read_value);
        if (out_rsp.status !== want.status)
          report_mismatch("status", WORD_W'(out_rsp.status), WORD_W'(want.status));
      end
    end
  end

  initial begin
    msk_req_t    r;
    msk_rsp_t    no_rsp;
    dir_row_t    row;
    op_bias_e    bias;
    logic [SEL_W-1:0] focus;
    int          sent;
    int          phase_left;
    int          burst;
    int          pauses_done;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    out_stall = 1'b0;
    no_rsp    = '0;
    for (int s = 0; s < NSTK; s++) begin
      fill_cnt[s] = 0;
      for (int i = 0; i < DEPTH; i++) stack_words[s][i] = '0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty stacks after reset, unused code, signed extremes
    add_row(CMD_POP,    2'd0, 32'h0000_0000, 1, 1, 32'h0, ST_UNDERFLOW);
    add_row(CMD_PEEK,   2'd3, 32'hFFFF_FFFF, 1, 1, 32'h0, ST_UNDERFLOW);
    add_row(CMD_UNUSED, 2'd1, 32'hFFFF_FFFF, 1, 1, 32'h0, ST_OK);
    add_row(CMD_PUSH,   2'd0, 32'h7FFF_FFFF, 1, 1, 32'h0, ST_OK);
    add_row(CMD_PUSH,   2'd0, 32'h8000_0000, 1, 1, 32'h0, ST_OK);
    add_row(CMD_PEEK,   2'd0, 32'h0000_0000, 1, 1, 32'h8000_0000, ST_OK);
    add_row(CMD_POP,    2'd0, 32'h0000_0000, 1, 1, 32'h8000_0000, ST_OK);
    add_row(CMD_POP,    2'd0, 32'hFFFF_FFFF, 1, 1, 32'h7FFF_FFFF, ST_OK);
    add_row(CMD_POP,    2'd0, 32'h0000_0000, 1, 1, 32'h0, ST_UNDERFLOW);
    add_row(CMD_PUSH,   2'd3, 32'hFFFF_FFFF, 1, 1, 32'h0, ST_OK);
    add_row(CMD_UNUSED, 2'd3, 32'h1234_5678, 1, 1, 32'h0, ST_OK);
    add_row(CMD_PEEK,   2'd3, 32'h0000_0000, 1, 1, 32'hFFFF_FFFF, ST_OK);
    // fill one stack to the top, then push once more for overflow
    add_row(CMD_PUSH,   2'd2, 32'hA5A5_0000, DEPTH, 1, 32'h0, ST_OK);
    add_row(CMD_PUSH,   2'd2, 32'h5555_5555, 1, 1, 32'h0, ST_OVERFLOW);
    add_row(CMD_PEEK,   2'd2, 32'h0000_0000, 1, 0, 32'h0, ST_OK);
    add_row(CMD_UNUSED, 2'd2, 32'hAAAA_AAAA, 1, 1, 32'h0, ST_OK);
    add_row(CMD_POP,    2'd2, 32'h0000_0000, DEPTH, 0, 32'h0, ST_OK);
    add_row(CMD_POP,    2'd2, 32'h0000_0000, 1, 1, 32'h0, ST_UNDERFLOW);
    add_row(CMD_PEEK,   2'd2, 32'h0000_0000, 1, 1, 32'h0, ST_UNDERFLOW);
    add_row(CMD_PUSH,   2'd1, 32'h0000_0000, 1, 1, 32'h0, ST_OK);
    add_row(CMD_POP,    2'd1, 32'hFFFF_FFFF, 1, 0, 32'h0, ST_OK);
    add_row(CMD_POP,    2'd3, 32'h0000_0000, 1, 1, 32'hFFFF_FFFF, ST_OK);

    foreach (dir_table[k]) begin
      row = dir_table[k];
      for (int n = 0; n < row.reps; n++) begin
        r.command      = row.cmd;
        r.stack_select = row.sel;
        r.push_value   = row.val + n;
        send_req(r, row.typed, row.rsp);
      end
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 4));
    end
    wait_drained();

    // random part: phases with a push, pop or mixed lean on a focus stack
    sent        = 0;
    phase_left  = 0;
    pauses_done = 0;
    bias        = BIAS_MIX;
    focus       = '0;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left <= 0) begin
        bias       = op_bias_e'($urandom_range(0, 2));
        focus      = SEL_W'($urandom_range(0, NSTK-1));
        phase_left = $urandom_range(30, 80);
      end
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        r = random_req(bias, focus);
        send_req(r, 1'b0, no_rsp);
        sent++;
        phase_left--;
      end
      if (pauses_done < 2 && sent >= (pauses_done + 1) * (RANDOM_ITEMS / 3)) begin
        wait_drained();
        pauses_done++;
      end else if ($urandom_range(0, 2) != 0) begin
        idle_cycles($urandom_range(1, 12));
      end
    end
    idle_cycles(1);

    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_rsp_q.size() != 0)
      report_mismatch("responses missing", pending_rsp_q.size(), '0);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
